FILE: rtl/core/hgbm_pkg.sv
// Shared constants and types for the group-by mean engine.
`default_nettype none
package hgbm_pkg;
   localparam int TableSlotsDefault = 256;
   localparam int KeyW   = 32;
   localparam int ValW   = 32;
   localparam int CountW = 32;
   localparam int SumW   = 64;
   localparam int MeanW  = 40;
   localparam int IdxW   = 8;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusFull  = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

   localparam logic OpAccum = 1'b0;
   localparam logic OpRead  = 1'b1;

   // datapath commands issued by the controller
   typedef struct packed {
      logic load_req;     // capture request beat
      logic set_probe;    // probe address <= home slot
      logic next_probe;   // probe address advance
      logic set_read;     // probe address <= slot_index
      logic rd_valid;     // sample valid bit of probe slot
      logic write_slot;   // write updated entry
      logic div_start;    // start mean divider
      logic load_rsp;     // capture response
      logic rsp_blank;    // blank response
      logic [1:0] rsp_status;
   } hgbm_cmd_type;

   typedef struct packed {
      logic opcode;
      logic slot_valid;   // probe slot valid
      logic key_match;    // probe slot key matches
      logic idx_in_range; // readout index below table size
      logic probe_last;   // all slots probed
      logic div_done;
   } hgbm_stat_type;
endpackage
`default_nettype wire

FILE: rtl/core/hgbm_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module hgbm_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      rd_data <= mem_ff[addr];
   end
endmodule
`default_nettype wire

FILE: rtl/core/hgbm_div.sv
// Bit-serial signed mean divider: sum*256/count, truncated, saturated to 40 bits.
`default_nettype none
module hgbm_div
   import hgbm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [SumW-1:0]   sum,
   input  wire logic [CountW-1:0] count,
   output logic                   done,
   output logic [MeanW-1:0]       mean
);
   localparam int NumW = SumW + 8;
   localparam int CntW = $clog2(NumW + 1);
   localparam logic [MeanW:0] LimPos = {2'b00, {(MeanW-1){1'b1}}};
   localparam logic [MeanW:0] LimNeg = {2'b01, {(MeanW-1){1'b0}}};

   logic [NumW-1:0]   num_ff, num_in;
   logic [CountW:0]   rem_ff, rem_in;
   logic [CountW-1:0] den_ff, den_in;
   logic              neg_ff, neg_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [SumW-1:0]   mag;
   logic [CountW:0]   trial, diff;
   logic [MeanW:0]    qlim, lim;
   logic              ovf;

   always_comb begin
      mag = sum[SumW-1] ? (~sum + 1'b1) : sum;
      num_in = num_ff; rem_in = rem_ff; den_in = den_ff; neg_in = neg_ff;
      busy_in = busy_ff; cnt_in = cnt_ff; done_in = 1'b0;
      trial = {rem_ff[CountW-1:0], num_ff[NumW-1]};
      diff = trial - {1'b0, den_ff};
      if (start) begin
         num_in = {mag, 8'd0};
         rem_in = '0; den_in = count; neg_in = sum[SumW-1];
         busy_in = 1'b1; cnt_in = CntW'(NumW);
      end else if (busy_ff) begin
         // one quotient bit per cycle, restoring
         if (trial >= {1'b0, den_ff}) begin
            rem_in = diff; num_in = {num_ff[NumW-2:0], 1'b1};
         end else begin
            rem_in = trial; num_in = {num_ff[NumW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_comb begin
      lim  = neg_ff ? LimNeg : LimPos;
      ovf  = |num_ff[NumW-1:MeanW+1];
      qlim = (ovf || num_ff[MeanW:0] > lim) ? lim : num_ff[MeanW:0];
      if (den_ff == '0) begin
         qlim = '0;
      end
      mean = neg_ff ? MeanW'(~qlim + 1'b1) : qlim[MeanW-1:0];
      done = done_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      num_ff <= num_in; rem_ff <= rem_in; den_ff <= den_in;
      neg_ff <= neg_in; cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

FILE: rtl/core/hgbm_datapath.sv
// Table storage, probe address, update arithmetic and response register.
`default_nettype none
module hgbm_datapath
   import hgbm_pkg::*;
#(
   parameter int TableSlots = TableSlotsDefault
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hgbm_cmd_type        cmd,
   output hgbm_stat_type            stat,
   input  wire logic                req_opcode,
   input  wire logic signed [KeyW-1:0] req_group_key,
   input  wire logic signed [ValW-1:0] req_row_value,
   input  wire logic [IdxW-1:0]     req_slot_index,
   output logic [1:0]               rsp_status,
   output logic [IdxW-1:0]          rsp_slot_used,
   output logic signed [KeyW-1:0]   rsp_key_out,
   output logic [CountW-1:0]        rsp_count_out,
   output logic signed [SumW-1:0]   rsp_sum_out,
   output logic signed [MeanW-1:0]  rsp_mean_out
);
   localparam int AW = $clog2(TableSlots);
   localparam int PW = $clog2(TableSlots + 1);
   localparam int EW = KeyW + SumW + CountW;

   logic              op_ff;
   logic [KeyW-1:0]   key_ff;
   logic [ValW-1:0]   val_ff;
   logic [IdxW-1:0]   idx_ff;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [PW-1:0]     probes_ff, probes_in;
   logic [TableSlots-1:0] valid_ff;
   logic              pvalid_ff;
   logic [EW-1:0]     rd_entry, wr_entry;
   logic [KeyW-1:0]   e_key;
   logic [SumW-1:0]   e_sum, new_sum, ext_val, raw;
   logic [CountW-1:0] e_count, new_count;
   logic [KeyW-1:0]   o_key;
   logic [SumW-1:0]   o_sum;
   logic [CountW-1:0] o_count;
   logic [MeanW-1:0]  mean;
   logic              div_done;
   logic [AW-1:0]     home;

   hgbm_ram #(.Width(EW), .Depth(TableSlots)) u_ram (
      .clock(clock), .wr_en(cmd.write_slot), .addr(addr_ff),
      .wr_data(wr_entry), .rd_data(rd_entry));

   assign {e_key, e_sum, e_count} = rd_entry;

   always_comb begin
      home = AW'(key_ff % TableSlots);
      addr_in = addr_ff; probes_in = probes_ff;
      if (cmd.set_probe) begin
         addr_in = home; probes_in = '0;
      end else if (cmd.next_probe) begin
         addr_in = (addr_ff == AW'(TableSlots - 1)) ? '0 : addr_ff + 1'b1;
         probes_in = probes_ff + 1'b1;
      end else if (cmd.set_read) begin
         addr_in = AW'(idx_ff);
      end
      // new slot starts from zero
      ext_val = {{(SumW-ValW){val_ff[ValW-1]}}, val_ff};
      o_sum   = pvalid_ff ? e_sum : '0;
      o_count = pvalid_ff ? e_count : '0;
      raw = o_sum + ext_val;
      new_sum = raw;
      if (o_sum[SumW-1] == ext_val[SumW-1] && raw[SumW-1] != o_sum[SumW-1]) begin
         new_sum = o_sum[SumW-1] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end
      new_count = (&o_count) ? o_count : o_count + 1'b1;
      wr_entry = {key_ff, new_sum, new_count};
      o_key = op_ff ? e_key : key_ff;
   end

   assign stat.opcode       = op_ff;
   assign stat.slot_valid   = pvalid_ff;
   assign stat.key_match    = (e_key == key_ff);
   assign stat.idx_in_range = (32'(idx_ff) < TableSlots);
   assign stat.probe_last   = (probes_ff == PW'(TableSlots));
   assign stat.div_done     = div_done;

   hgbm_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .sum(op_ff ? e_sum : new_sum), .count(op_ff ? e_count : new_count),
      .done(div_done), .mean(mean));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.write_slot) begin
         valid_ff[addr_ff] <= 1'b1;
      end
      if (cmd.load_req) begin
         op_ff <= req_opcode; key_ff <= req_group_key;
         val_ff <= req_row_value; idx_ff <= req_slot_index;
      end
      if (cmd.rd_valid) begin
         pvalid_ff <= valid_ff[addr_ff];
      end
      addr_ff <= addr_in; probes_ff <= probes_in;
      // hold entry for readout: reuse sum/count after write via stored regs
      if (cmd.write_slot) begin
         rsp_sum_out   <= new_sum;
         rsp_count_out <= new_count;
         rsp_key_out   <= key_ff;
      end else if (cmd.div_start) begin
         rsp_sum_out   <= e_sum;
         rsp_count_out <= e_count;
         rsp_key_out   <= o_key;
      end
      if (cmd.load_rsp) begin
         rsp_status <= cmd.rsp_status;
         if (cmd.rsp_blank) begin
            rsp_slot_used <= (cmd.rsp_status == StatusFull) ? '0 : idx_ff;
            rsp_key_out <= '0; rsp_count_out <= '0;
            rsp_sum_out <= '0; rsp_mean_out <= '0;
         end else begin
            rsp_slot_used <= IdxW'(addr_ff);
            rsp_mean_out  <= mean;
         end
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/hgbm_ctrl.sv
// Controller state machine for probe, update, divide and response.
`default_nettype none
module hgbm_ctrl
   import hgbm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire hgbm_stat_type stat,
   output hgbm_cmd_type       cmd
);
   typedef enum logic [2:0] {
      S_IDLE, S_ADDR, S_READ, S_CHECK, S_DIV, S_RSP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic [1:0] stat_ff;
   logic      blank_ff;

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd = '0;
      cmd.rsp_status = stat_ff;
      cmd.rsp_blank  = blank_ff;
      case (state_ff)
         S_IDLE:  cmd.load_req = req_valid && req_ready;
         S_ADDR: begin
            if (stat.opcode == OpRead) cmd.set_read = 1'b1;
            else cmd.set_probe = 1'b1;
         end
         S_READ:  cmd.rd_valid = 1'b1;
         S_CHECK: begin
            if (stat.opcode == OpRead) begin
               cmd.div_start = stat.slot_valid && stat.idx_in_range;
            end else if (stat.probe_last) begin
               cmd.div_start = 1'b0;
            end else if (!stat.slot_valid || stat.key_match) begin
               cmd.write_slot = 1'b1; cmd.div_start = 1'b1;
            end else begin
               cmd.next_probe = 1'b1;
            end
         end
         S_DIV:   cmd.load_rsp = stat.div_done;
         S_RSP:   cmd.load_rsp = 1'b1;
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; rsp_valid_ff <= 1'b0;
         stat_ff <= StatusOk; blank_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE:  if (req_valid && req_ready) state_ff <= S_ADDR;
            S_ADDR:  state_ff <= S_READ;
            S_READ:  state_ff <= S_CHECK;
            S_CHECK: begin
               if (stat.opcode == OpRead) begin
                  if (stat.slot_valid && stat.idx_in_range) begin
                     stat_ff <= StatusOk; blank_ff <= 1'b0; state_ff <= S_DIV;
                  end else begin
                     stat_ff <= StatusEmpty; blank_ff <= 1'b1; state_ff <= S_RSP;
                  end
               end else if (stat.probe_last) begin
                  stat_ff <= StatusFull; blank_ff <= 1'b1; state_ff <= S_RSP;
               end else if (!stat.slot_valid || stat.key_match) begin
                  stat_ff <= StatusOk; blank_ff <= 1'b0; state_ff <= S_DIV;
               end else begin
                  state_ff <= S_READ;
               end
            end
            S_DIV: if (stat.div_done) begin
               rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            S_RSP: begin
               rsp_valid_ff <= 1'b1; state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: rtl/core/hash_group_by_mean.sv
// Top level of the hash group-by engine: sum, count and mean per key.
// Sequence to rsp_valid: an accumulate beat reads and checks each probed slot in turn,
// then runs the 72-step bit-serial mean divider; a readout of a held slot also divides;
// an empty-slot readout and a dropped row (all slots probed) skip the divider.
// Throughput: one beat at a time; a new request is taken only in idle, after the last response is accepted.
// Reset: synchronous, active high; clears slot valid marks and the controller.
`default_nettype none
module hash_group_by_mean
   import hgbm_pkg::*;
#(
   parameter int TableSlots = TableSlotsDefault
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_opcode,
   input  wire logic signed [KeyW-1:0] req_group_key,
   input  wire logic signed [ValW-1:0] req_row_value,
   input  wire logic [IdxW-1:0]        req_slot_index,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [IdxW-1:0]             rsp_slot_used,
   output logic signed [KeyW-1:0]      rsp_key_out,
   output logic [CountW-1:0]           rsp_count_out,
   output logic signed [SumW-1:0]      rsp_sum_out,
   output logic signed [MeanW-1:0]     rsp_mean_out
);
   hgbm_cmd_type  cmd;
   hgbm_stat_type stat;

   // controller: sequence probe, update, divide and response beat
   hgbm_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .stat(stat), .cmd(cmd));

   // datapath: table RAM, valid marks, saturating update, mean divider
   hgbm_datapath #(.TableSlots(TableSlots)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_opcode(req_opcode), .req_group_key(req_group_key),
      .req_row_value(req_row_value), .req_slot_index(req_slot_index),
      .rsp_status(rsp_status), .rsp_slot_used(rsp_slot_used),
      .rsp_key_out(rsp_key_out), .rsp_count_out(rsp_count_out),
      .rsp_sum_out(rsp_sum_out), .rsp_mean_out(rsp_mean_out));
endmodule
`default_nettype wire

FILE: sim/hash_group_by_mean_tb.sv
// Self-checking bench for the hash group-by engine: random rows and readouts vs. a table model.
`timescale 1ns / 100ps
`default_nettype none
module hash_group_by_mean_tb;
   import hgbm_pkg::*;

   localparam int Slots     = TableSlotsDefault;
   localparam int CycleCap  = 2000000;
   localparam int DrainWait = 200;

   typedef struct {
      logic                   opcode;
      logic signed [KeyW-1:0] group_key;
      logic signed [ValW-1:0] row_value;
      logic [IdxW-1:0]        slot_index;
   } row_beat_type;

   typedef struct {
      logic [1:0]              status;
      logic [IdxW-1:0]         slot_used;
      logic signed [KeyW-1:0]  key_out;
      logic [CountW-1:0]       count_out;
      logic signed [SumW-1:0]  sum_out;
      logic signed [MeanW-1:0] mean_out;
   } group_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic                    req_opcode = OpAccum;
   logic signed [KeyW-1:0]  req_group_key = '0;
   logic signed [ValW-1:0]  req_row_value = '0;
   logic [IdxW-1:0]         req_slot_index = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic [1:0]              rsp_status;
   logic [IdxW-1:0]         rsp_slot_used;
   logic signed [KeyW-1:0]  rsp_key_out;
   logic [CountW-1:0]       rsp_count_out;
   logic signed [SumW-1:0]  rsp_sum_out;
   logic signed [MeanW-1:0] rsp_mean_out;

   hash_group_by_mean dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_group_key(req_group_key),
      .req_row_value(req_row_value), .req_slot_index(req_slot_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_status(rsp_status), .rsp_slot_used(rsp_slot_used),
      .rsp_key_out(rsp_key_out), .rsp_count_out(rsp_count_out),
      .rsp_sum_out(rsp_sum_out), .rsp_mean_out(rsp_mean_out)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Shadow copy of the group table.
   logic                   tbl_valid [Slots];
   logic signed [KeyW-1:0] tbl_key   [Slots];
   logic signed [SumW-1:0] tbl_sum   [Slots];
   logic [CountW-1:0]      tbl_count [Slots];

   row_beat_type  rows_to_send[$];
   group_rsp_type rsp_due[$];
   row_beat_type  row_in_flight;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches    = 0;
   int cycles        = 0;

   // Mean as sum*256/count, truncated toward zero, clamped to the 40-bit range.
   function automatic logic signed [MeanW-1:0] group_mean(logic signed [SumW-1:0] sum,
                                                          logic [CountW-1:0] count);
      logic                  neg;
      logic [63:0]           mag, q, r, m, lim;
      neg = sum[SumW-1];
      mag = neg ? (~sum + 64'd1) : sum;
      lim = neg ? 64'd549755813888 : 64'd549755813887;
      if (count == 0) return '0;
      q = mag / count;
      r = mag % count;
      if (q >= 64'h1_0000_0000) begin
         m = lim;
      end else begin
         m = (q << 8) + ((r << 8) / count);
         if (m > lim) m = lim;
      end
      if (neg) m = ~m + 64'd1;
      return m[MeanW-1:0];
   endfunction

   function automatic group_rsp_type slot_view(int s);
      group_rsp_type g;
      g.status    = StatusOk;
      g.slot_used = s[IdxW-1:0];
      g.key_out   = tbl_key[s];
      g.count_out = tbl_count[s];
      g.sum_out   = tbl_sum[s];
      g.mean_out  = group_mean(tbl_sum[s], tbl_count[s]);
      return g;
   endfunction

   // Apply one accepted beat to the shadow table and return the expected response.
   function automatic group_rsp_type aggregate_row(row_beat_type b);
      group_rsp_type          g;
      int                     s, n;
      logic signed [SumW:0]   wide;
      g = '{default: '0};
      if (b.opcode == OpRead) begin
         if (tbl_valid[b.slot_index]) return slot_view(b.slot_index);
         g.status    = StatusEmpty;
         g.slot_used = b.slot_index;
         return g;
      end
      s = int'(unsigned'(b.group_key) % Slots);
      for (n = 0; n < Slots; n++) begin
         if (!tbl_valid[s]) begin
            tbl_valid[s] = 1'b1;
            tbl_key[s]   = b.group_key;
            tbl_sum[s]   = '0;
            tbl_count[s] = '0;
            break;
         end
         if (tbl_key[s] == b.group_key) break;
         s = (s + 1 == Slots) ? 0 : s + 1;
      end
      if (n == Slots) begin
         g.status = StatusFull;
         return g;
      end
      wide = tbl_sum[s] + b.row_value;
      if (wide > 65'sh0_7FFF_FFFF_FFFF_FFFF)       tbl_sum[s] = 64'h7FFF_FFFF_FFFF_FFFF;
      else if (wide < -65'sh0_8000_0000_0000_0000) tbl_sum[s] = 64'h8000_0000_0000_0000;
      else                                         tbl_sum[s] = wide[SumW-1:0];
      if (tbl_count[s] != '1) tbl_count[s] = tbl_count[s] + 1;
      return slot_view(s);
   endfunction

   // Driver: predict on acceptance, then present the next beat or idle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            rsp_due.push_back(aggregate_row(row_in_flight));
         end
         if (!req_valid || req_ready) begin
            if (rows_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               row_in_flight   = rows_to_send.pop_front();
               req_opcode     <= row_in_flight.opcode;
               req_group_key  <= row_in_flight.group_key;
               req_row_value  <= row_in_flight.row_value;
               req_slot_index <= row_in_flight.slot_index;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: stall at random, check each response beat against the oldest prediction.
   always @(posedge clock) begin
      group_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            if (rsp_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: status %0d slot %0d",
                           rsp_status, rsp_slot_used);
            end else begin
               want = rsp_due.pop_front();
               if (rsp_status !== want.status || rsp_slot_used !== want.slot_used
                   || rsp_key_out !== want.key_out || rsp_count_out !== want.count_out
                   || rsp_sum_out !== want.sum_out || rsp_mean_out !== want.mean_out) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch: exp st %0d slot %0d key %0d cnt %0d sum %0d mean %0d",
                              want.status, want.slot_used, want.key_out, want.count_out,
                              want.sum_out, want.mean_out);
                     $display("          got st %0d slot %0d key %0d cnt %0d sum %0d mean %0d",
                              rsp_status, rsp_slot_used, rsp_key_out, rsp_count_out,
                              rsp_sum_out, rsp_mean_out);
                  end
               end
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleCap) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Pool of keys, many sharing low bytes so probe chains form.
   logic signed [KeyW-1:0] key_pool [40];

   task automatic add_row(logic op, logic signed [KeyW-1:0] k, logic signed [ValW-1:0] v,
                          logic [IdxW-1:0] idx);
      row_beat_type b;
      b.opcode = op; b.group_key = k; b.row_value = v; b.slot_index = idx;
      rows_to_send.push_back(b);
   endtask

   task automatic add_random_rows(int count, bit fresh_keys);
      int                     pick;
      logic signed [KeyW-1:0] k;
      logic signed [ValW-1:0] v;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         k = key_pool[$urandom_range(39)];
         v = $urandom;
         if ($urandom_range(9) == 0) v = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         if (pick < 6 || (fresh_keys && pick < 20)) k = $urandom;
         if (pick >= 85) begin
            // readout: half the time the home slot of a pool key, otherwise any slot
            add_row(OpRead, $urandom, $urandom,
                    $urandom_range(1) ? k[IdxW-1:0] : IdxW'($urandom));
         end else begin
            add_row(OpAccum, k, v, IdxW'($urandom));
         end
      end
   endtask

   task automatic drain;
      while (rows_to_send.size() > 0 || req_valid || rsp_due.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      for (int s = 0; s < Slots; s++) begin
         tbl_valid[s] = 1'b0;
         tbl_key[s]   = '0;
         tbl_sum[s]   = '0;
         tbl_count[s] = '0;
      end
      for (int i = 0; i < 40; i++)
         key_pool[i] = {24'($urandom), 8'($urandom_range(15))};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 16;
      recv_idle_pct = 66;
      // empty slots, both ends of the table
      add_row(OpRead, 0, 0, 8'd0);
      add_row(OpRead, -1, -1, 8'd255);
      add_row(OpRead, 0, 0, 8'd7);
      // same key twice at the value limit, then a colliding key
      add_row(OpAccum, 0, 32'sh7FFF_FFFF, 8'd0);
      add_row(OpAccum, 0, 32'sh7FFF_FFFF, 8'd0);
      add_row(OpAccum, 256, 32'sh8000_0000, 8'd0);
      add_row(OpAccum, -1, 32'sh8000_0000, 8'd0);
      add_row(OpAccum, 32'sh8000_0000, -1, 8'd0);
      // home slot 255 taken: wrap around to the start of the table
      add_row(OpAccum, 32'sh7FFF_FFFF, 1, 8'd0);
      add_row(OpAccum, 255, 0, 8'd0);
      add_row(OpRead, 0, 0, 8'd0);
      add_row(OpRead, 0, 0, 8'd1);
      add_row(OpRead, 0, 0, 8'd2);
      add_row(OpRead, 0, 0, 8'd3);
      add_row(OpRead, 0, 0, 8'd4);
      add_row(OpRead, 0, 0, 8'd255);
      // negative sum on key 5, then read its slot
      add_row(OpAccum, 5, -7, 8'd0);
      add_row(OpAccum, 5, 2, 8'd0);
      add_row(OpRead, 32'h1234_5678, 32'h0BAD_F00D, 8'd5);
      add_random_rows(300, 1'b0);
      drain;

      send_idle_pct = 66;
      recv_idle_pct = 16;
      add_random_rows(300, 1'b0);
      drain;

      // no idling; fill the table with distinct keys until rows get dropped
      send_idle_pct = 0;
      recv_idle_pct = 0;
      for (int i = 0; i < 300; i++)
         add_row(i % 7 == 0 ? OpRead : OpAccum, 32'sh5A00_0000 + i, $urandom, IdxW'($urandom));
      add_random_rows(150, 1'b1);
      drain;

      repeat (DrainWait) @(posedge clock);
      if (mismatches == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end
endmodule
`default_nettype wire

FILE: files.f
rtl/core/hgbm_pkg.sv
rtl/core/hgbm_ram.sv
rtl/core/hgbm_div.sv
rtl/core/hgbm_datapath.sv
rtl/core/hgbm_ctrl.sv
rtl/core/hash_group_by_mean.sv
sim/hash_group_by_mean_tb.sv
